// ----- rtl/gpe_pkg.sv -----
// Shared package of the gradient program evaluator: sizes, codes and the
// float unit request/response structs. No dependencies.
`default_nettype none

package gpe_pkg;

   localparam int PROGRAM_DEPTH = 8;
   localparam int CONST_COUNT   = 12;
   localparam int IADDR_W = (PROGRAM_DEPTH > 1) ? $clog2(PROGRAM_DEPTH) : 1;
   localparam int CADDR_W = (CONST_COUNT > 1) ? $clog2(CONST_COUNT) : 1;
   localparam int RF_DEPTH = 10;
   localparam int RADDR_W  = 4;
   localparam int CNT_W    = 5;

   localparam logic [1:0] OP_WRITE_INSTR = 2'd0;
   localparam logic [1:0] OP_WRITE_CONST = 2'd1;
   localparam logic [1:0] OP_EVAL        = 2'd2;

   localparam logic [2:0] ERR_NONE    = 3'd0;
   localparam logic [2:0] ERR_SOURCE  = 3'd1;
   localparam logic [2:0] ERR_OPCODE  = 3'd2;
   localparam logic [2:0] ERR_DEST    = 3'd3;
   localparam logic [2:0] ERR_SLOT    = 3'd4;

   localparam logic [1:0] OPC_DOT     = 2'd0;
   localparam logic [1:0] OPC_SQRTMUL = 2'd2;

   localparam logic [4:0] SRC_LAST_REG  = 5'd9;
   localparam logic [4:0] SRC_CONST0    = 5'd16;
   localparam logic [4:0] SRC_CONST_END = 5'd27;
   localparam logic [4:0] SRC_ONE       = 5'd29;
   localparam logic [4:0] SRC_MINUSONE  = 5'd30;
   localparam logic [3:0] DST_LAST      = 4'd9;

   localparam logic [RADDR_W-1:0] REG_X    = 4'd0;
   localparam logic [RADDR_W-1:0] REG_Y    = 4'd1;
   localparam logic [RADDR_W-1:0] REG_OUTX = 4'd8;
   localparam logic [RADDR_W-1:0] REG_OUTY = 4'd9;

   localparam logic [31:0] FP_ONE         = 32'h3F80_0000;
   localparam logic [31:0] FP_MINUSONE    = 32'hBF80_0000;
   localparam logic [31:0] FP_QNAN        = 32'h7FC0_0000;
   localparam logic [31:0] FP_DEFAULT_NAN = 32'hFFC0_0000;
   localparam logic [31:0] FP_QUIET_BIT   = 32'h0040_0000;

   localparam logic [1:0] FPU_CVT  = 2'd0;
   localparam logic [1:0] FPU_MUL  = 2'd1;
   localparam logic [1:0] FPU_ADD  = 2'd2;
   localparam logic [1:0] FPU_SQRT = 2'd3;

   typedef struct packed {
      logic        start;
      logic [1:0]  op;
      logic [31:0] a;
      logic [31:0] b;
   } fpu_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] result;
   } fpu_rsp_type;

   function automatic logic readable(input logic [4:0] src);
      return (src <= SRC_LAST_REG) || (src >= SRC_CONST0 && src <= SRC_MINUSONE);
   endfunction

endpackage

`default_nettype wire

// ----- rtl/gpe_req_if.sv -----
// Input channel of the gradient program evaluator: valid/ready plus word fields.
// No dependencies.
`default_nettype none

interface gpe_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         op;
   logic [3:0]         slot;
   logic [31:0]        word;
   logic signed [15:0] pixel_x;
   logic signed [15:0] pixel_y;

   modport source (output valid, op, slot, word, pixel_x, pixel_y, input ready);
   modport sink (input valid, op, slot, word, pixel_x, pixel_y, output ready);
endinterface

`default_nettype wire

// ----- rtl/gpe_rsp_if.sv -----
// Result channel of the gradient program evaluator: valid/ready plus result fields.
// No dependencies.
`default_nettype none

interface gpe_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] out_x;
   logic [31:0] out_y;
   logic [2:0]  error;

   modport source (output valid, out_x, out_y, error, input ready);
   modport sink (input valid, out_x, out_y, error, output ready);
endinterface

`default_nettype wire

// ----- rtl/gpe_ram.sv -----
// Generic single write port RAM with registered read.
// No dependencies.
`default_nettype none

module gpe_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                   clock,
   input  wire logic                   we,
   input  wire logic [AW-1:0]          waddr,
   input  wire logic [WIDTH-1:0]       wdata,
   input  wire logic [AW-1:0]          raddr,
   output logic      [WIDTH-1:0]       rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

`default_nettype wire

// ----- rtl/gpe_fpu.sv -----
// Shared single-precision unit: int16 convert, multiply, add, square root.
// One step per cycle; depends on gpe_pkg.
`default_nettype none

module gpe_fpu import gpe_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire fpu_req_type  fpu_req,
   output fpu_rsp_type       fpu_rsp
);
   localparam logic [3:0] F_IDLE    = 4'd0;
   localparam logic [3:0] F_PRENORM = 4'd1;
   localparam logic [3:0] F_MUL     = 4'd2;
   localparam logic [3:0] F_ADD     = 4'd3;
   localparam logic [3:0] F_NORM    = 4'd4;
   localparam logic [3:0] F_DENORM  = 4'd5;
   localparam logic [3:0] F_ROUND   = 4'd6;
   localparam logic [3:0] F_SQRT    = 4'd7;
   localparam logic [3:0] F_SQFIN   = 4'd8;
   localparam logic [3:0] F_DONE    = 4'd9;

   logic [3:0]         state_ff, state_in;
   logic [1:0]         op_ff, op_in;
   logic               sa_ff, sa_in, sb_ff, sb_in, sgn_ff, sgn_in;
   logic [23:0]        ma_ff, ma_in, mb_ff, mb_in;
   logic signed [10:0] ea_ff, ea_in, eb_ff, eb_in, e_ff, e_in;
   logic [27:0]        m_ff, m_in;
   logic [31:0]        res_ff, res_in;
   logic [49:0]        rem_ff, rem_in, q_ff, q_in, bit_ff, bit_in;

   logic [7:0]  a_exp, b_exp;
   logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sx;
   logic        spec;
   logic [31:0] spec_res;
   logic [15:0] abs_x;

   assign a_exp  = fpu_req.a[30:23];
   assign b_exp  = fpu_req.b[30:23];
   assign a_nan  = (a_exp == 8'hFF) && (fpu_req.a[22:0] != '0);
   assign b_nan  = (b_exp == 8'hFF) && (fpu_req.b[22:0] != '0);
   assign a_inf  = (a_exp == 8'hFF) && (fpu_req.a[22:0] == '0);
   assign b_inf  = (b_exp == 8'hFF) && (fpu_req.b[22:0] == '0);
   assign a_zero = (fpu_req.a[30:0] == '0);
   assign b_zero = (fpu_req.b[30:0] == '0);
   assign sx     = fpu_req.a[31] ^ fpu_req.b[31];
   assign abs_x  = fpu_req.a[15] ? (16'd0 - fpu_req.a[15:0]) : fpu_req.a[15:0];

   always_comb begin
      spec = 1'b0;
      spec_res = '0;
      case (fpu_req.op)
         FPU_MUL: begin
            if (a_nan) begin
               spec = 1'b1; spec_res = fpu_req.a | FP_QUIET_BIT;
            end else if (b_nan) begin
               spec = 1'b1; spec_res = fpu_req.b | FP_QUIET_BIT;
            end else if ((a_inf && b_zero) || (a_zero && b_inf)) begin
               spec = 1'b1; spec_res = FP_DEFAULT_NAN;
            end else if (a_inf || b_inf) begin
               spec = 1'b1; spec_res = {sx, 8'hFF, 23'd0};
            end else if (a_zero || b_zero) begin
               spec = 1'b1; spec_res = {sx, 31'd0};
            end
         end
         FPU_ADD: begin
            if (a_nan) begin
               spec = 1'b1; spec_res = fpu_req.a | FP_QUIET_BIT;
            end else if (b_nan) begin
               spec = 1'b1; spec_res = fpu_req.b | FP_QUIET_BIT;
            end else if (a_inf && b_inf) begin
               spec = 1'b1;
               spec_res = sx ? FP_DEFAULT_NAN : fpu_req.a;
            end else if (a_inf) begin
               spec = 1'b1; spec_res = fpu_req.a;
            end else if (b_inf) begin
               spec = 1'b1; spec_res = fpu_req.b;
            end else if (a_zero && b_zero) begin
               spec = 1'b1; spec_res = {fpu_req.a[31] & fpu_req.b[31], 31'd0};
            end else if (a_zero) begin
               spec = 1'b1; spec_res = fpu_req.b;
            end else if (b_zero) begin
               spec = 1'b1; spec_res = fpu_req.a;
            end
         end
         FPU_SQRT: begin
            if (a_nan) begin
               spec = 1'b1; spec_res = fpu_req.a | FP_QUIET_BIT;
            end else if (a_zero) begin
               spec = 1'b1; spec_res = fpu_req.a;
            end else if (fpu_req.a[31]) begin
               spec = 1'b1; spec_res = FP_QNAN;
            end else if (a_inf) begin
               spec = 1'b1; spec_res = fpu_req.a;
            end
         end
         default: begin
            if (fpu_req.a[15:0] == '0) begin
               spec = 1'b1; spec_res = '0;
            end
         end
      endcase
   end

   // adder alignment
   logic               a_big, sh_sgn, sticky;
   logic [23:0]        mh, ml;
   logic signed [10:0] eh, el, d;
   logic [26:0]        small27, sh27;
   logic [27:0]        aligned, big28, sum28;

   always_comb begin
      a_big   = (ea_ff > eb_ff) || ((ea_ff == eb_ff) && (ma_ff >= mb_ff));
      mh      = a_big ? ma_ff : mb_ff;
      ml      = a_big ? mb_ff : ma_ff;
      eh      = a_big ? ea_ff : eb_ff;
      el      = a_big ? eb_ff : ea_ff;
      sh_sgn  = a_big ? sa_ff : sb_ff;
      d       = eh - el;
      small27 = {ml, 3'b000};
      sh27    = small27 >> d[4:0];
      sticky  = ((sh27 << d[4:0]) != small27);
      if (d > 11'sd26) begin
         aligned = {27'd0, |ml};
      end else begin
         aligned = {1'b0, sh27[26:1], sh27[0] | sticky};
      end
      big28 = {1'b0, mh, 3'b000};
      sum28 = (sa_ff == sb_ff) ? (big28 + aligned) : (big28 - aligned);
   end

   // sqrt helpers
   logic               odd;
   logic [24:0]        mant25;
   logic signed [10:0] eu;
   logic [49:0]        sq_t, qq;
   logic [47:0]        prod;
   logic               rnd_up;
   logic [7:0]         expf;
   logic [30:0]        packed31;

   always_comb begin
      odd    = ~ea_ff[0];
      mant25 = odd ? {ma_ff, 1'b0} : {1'b0, ma_ff};
      eu     = ea_ff - 11'sd127 - (odd ? 11'sd1 : 11'sd0);
      sq_t   = q_ff + bit_ff;
      qq     = q_ff + ((rem_ff > q_ff) ? 50'd1 : 50'd0);
      prod   = ma_ff * mb_ff;
      rnd_up = m_ff[2] & (m_ff[1] | m_ff[0] | m_ff[3]);
      expf   = m_ff[26] ? e_ff[7:0] : 8'd0;
      packed31 = {expf, m_ff[25:3]} + {30'd0, rnd_up};
   end

   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      sa_in = sa_ff; sb_in = sb_ff; sgn_in = sgn_ff;
      ma_in = ma_ff; mb_in = mb_ff;
      ea_in = ea_ff; eb_in = eb_ff; e_in = e_ff;
      m_in = m_ff; res_in = res_ff;
      rem_in = rem_ff; q_in = q_ff; bit_in = bit_ff;
      case (state_ff)
         F_IDLE: begin
            if (fpu_req.start) begin
               op_in = fpu_req.op;
               sa_in = fpu_req.a[31];
               sb_in = fpu_req.b[31];
               ma_in = {a_exp != 8'd0, fpu_req.a[22:0]};
               mb_in = (fpu_req.op == FPU_SQRT) ? 24'h80_0000
                                                 : {b_exp != 8'd0, fpu_req.b[22:0]};
               ea_in = (a_exp == 8'd0) ? 11'sd1 : $signed({3'b000, a_exp});
               eb_in = (b_exp == 8'd0) ? 11'sd1 : $signed({3'b000, b_exp});
               m_in   = {1'b0, abs_x, 11'd0};
               e_in   = 11'sd142;
               sgn_in = fpu_req.a[15];
               if (spec) begin
                  res_in = spec_res;
                  state_in = F_DONE;
               end else begin
                  case (fpu_req.op)
                     FPU_CVT: state_in = F_NORM;
                     FPU_ADD: state_in = F_ADD;
                     default: state_in = F_PRENORM;
                  endcase
               end
            end
         end
         F_PRENORM: begin
            if (!ma_ff[23]) begin
               ma_in = {ma_ff[22:0], 1'b0};
               ea_in = ea_ff - 11'sd1;
            end
            if (!mb_ff[23]) begin
               mb_in = {mb_ff[22:0], 1'b0};
               eb_in = eb_ff - 11'sd1;
            end
            if (ma_ff[23] && mb_ff[23]) begin
               if (op_ff == FPU_MUL) begin
                  state_in = F_MUL;
               end else begin
                  e_in   = (eu >>> 1) + 11'sd126;
                  rem_in = {2'b00, mant25, 23'd0};
                  q_in   = '0;
                  bit_in = 50'd1 << 48;
                  state_in = F_SQRT;
               end
            end
         end
         F_MUL: begin
            m_in   = {prod[47:21], |prod[20:0]};
            e_in   = ea_ff + eb_ff - 11'sd127;
            sgn_in = sa_ff ^ sb_ff;
            state_in = F_NORM;
         end
         F_ADD: begin
            if (sum28 == '0) begin
               res_in = '0;
               state_in = F_DONE;
            end else begin
               m_in   = sum28;
               e_in   = eh;
               sgn_in = sh_sgn;
               state_in = F_NORM;
            end
         end
         F_NORM: begin
            if (m_ff[27]) begin
               m_in = {1'b0, m_ff[27:2], m_ff[1] | m_ff[0]};
               e_in = e_ff + 11'sd1;
            end else if (!m_ff[26] && (e_ff > 11'sd1)) begin
               m_in = {m_ff[26:0], 1'b0};
               e_in = e_ff - 11'sd1;
            end else if (e_ff < 11'sd1) begin
               state_in = F_DENORM;
            end else begin
               state_in = F_ROUND;
            end
         end
         F_DENORM: begin
            if (e_ff < -11'sd40) begin
               m_in = {27'd0, |m_ff};
               e_in = 11'sd1;
            end else if (e_ff < 11'sd1) begin
               m_in = {1'b0, m_ff[27:2], m_ff[1] | m_ff[0]};
               e_in = e_ff + 11'sd1;
            end else begin
               state_in = F_ROUND;
            end
         end
         F_ROUND: begin
            if (e_ff > 11'sd254) begin
               res_in = {sgn_ff, 8'hFF, 23'd0};
            end else begin
               res_in = {sgn_ff, packed31};
            end
            state_in = F_DONE;
         end
         F_SQRT: begin
            if (rem_ff >= sq_t) begin
               rem_in = rem_ff - sq_t;
               q_in   = (q_ff >> 1) + bit_ff;
            end else begin
               q_in = q_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (bit_ff[0]) begin
               state_in = F_SQFIN;
            end
         end
         F_SQFIN: begin
            res_in = {1'b0, e_ff[7:0], 23'd0} + qq[31:0];
            state_in = F_DONE;
         end
         F_DONE: begin
            state_in = F_IDLE;
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      op_ff <= op_in;
      sa_ff <= sa_in; sb_ff <= sb_in; sgn_ff <= sgn_in;
      ma_ff <= ma_in; mb_ff <= mb_in;
      ea_ff <= ea_in; eb_ff <= eb_in; e_ff <= e_in;
      m_ff <= m_in; res_ff <= res_in;
      rem_ff <= rem_in; q_ff <= q_in; bit_ff <= bit_in;
   end

   assign fpu_rsp.done   = (state_ff == F_DONE);
   assign fpu_rsp.result = res_ff;
endmodule

`default_nettype wire

// ----- rtl/gradient_program_evaluator.sv -----
// Top level of the gradient program evaluator: sequencer, stores, APB registers.
// Depends on gpe_pkg, gpe_req_if, gpe_rsp_if, gpe_ram and gpe_fpu.
//
//   port group   dir   carries
//   req_ch       in    op, slot, word, pixel_x, pixel_y (valid/ready)
//   rsp_ch       out   out_x, out_y, error (valid/ready)
//   APB          in    program_length at byte address 0
//
// A store word is answered in the cycle after it is taken. A pixel runs two
// int-to-float conversions, then per instruction a fetch, five source reads
// and four or five ops on the one float unit (the fifth is the 25-step
// square root), then two reads of OUTX/OUTY.
// Synchronous reset clears control state and the store valid bits.
// req_ch.ready is low while a word is in work or a result waits on rsp_ch.
`default_nettype none

module gradient_program_evaluator import gpe_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   gpe_req_if.sink          req_ch,
   gpe_rsp_if.source        rsp_ch,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic      [31:0] prdata,
   output logic             pready
);
   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_CVTX   = 4'd1;
   localparam logic [3:0] S_CVTY   = 4'd2;
   localparam logic [3:0] S_IFETCH = 4'd3;
   localparam logic [3:0] S_IDEC   = 4'd4;
   localparam logic [3:0] S_SRCA   = 4'd5;
   localparam logic [3:0] S_SRCD   = 4'd6;
   localparam logic [3:0] S_SQRT   = 4'd7;
   localparam logic [3:0] S_MUL1   = 4'd8;
   localparam logic [3:0] S_MUL2   = 4'd9;
   localparam logic [3:0] S_ADD1   = 4'd10;
   localparam logic [3:0] S_ADD2   = 4'd11;
   localparam logic [3:0] S_OUTA   = 4'd12;
   localparam logic [3:0] S_OUTX   = 4'd13;
   localparam logic [3:0] S_OUTY   = 4'd14;

   logic [3:0]               state_ff, state_in;
   logic [3:0]               pl_ff, pl_in;
   logic [PROGRAM_DEPTH-1:0] inst_valid_ff, inst_valid_in;
   logic [CONST_COUNT-1:0]   const_valid_ff, const_valid_in;
   logic [RF_DEPTH-1:0]      rf_valid_ff, rf_valid_in;
   logic [15:0]              px_ff, px_in, py_ff, py_in;
   logic [CNT_W-1:0]         pc_ff, pc_in;
   logic [2:0]               k_ff, k_in;
   logic [31:0]              instr_ff, instr_in;
   logic [31:0]              opnd_ff [5];
   logic [31:0]              opnd_in [5];
   logic                     fpu_wait_ff, fpu_wait_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [31:0]              out_x_ff, out_x_in, out_y_ff, out_y_in;
   logic [2:0]               error_ff, error_in;

   logic                     inst_we, const_we, rf_we;
   logic [IADDR_W-1:0]       inst_raddr;
   logic [CADDR_W-1:0]       const_raddr;
   logic [RADDR_W-1:0]       rf_raddr, rf_waddr;
   logic [31:0]              inst_rdata, const_rdata, rf_rdata;

   fpu_req_type              fpu_req;
   fpu_rsp_type              fpu_rsp;
   logic                     fpu_active;

   logic                     accept;
   logic [CNT_W-1:0]         n_run, pc_next;
   logic [4:0]               src_cur;
   logic [31:0]              src_val, dec_word;
   logic                     bad_src, bad_opc, bad_dst;

   gpe_ram #(.WIDTH(32), .DEPTH(PROGRAM_DEPTH)) u_inst_ram (
      .clock (clock),
      .we    (inst_we),
      .waddr (req_ch.slot[IADDR_W-1:0]),
      .wdata (req_ch.word),
      .raddr (inst_raddr),
      .rdata (inst_rdata)
   );

   gpe_ram #(.WIDTH(32), .DEPTH(CONST_COUNT)) u_const_ram (
      .clock (clock),
      .we    (const_we),
      .waddr (req_ch.slot[CADDR_W-1:0]),
      .wdata (req_ch.word),
      .raddr (const_raddr),
      .rdata (const_rdata)
   );

   gpe_ram #(.WIDTH(32), .DEPTH(RF_DEPTH)) u_rf_ram (
      .clock (clock),
      .we    (rf_we),
      .waddr (rf_waddr),
      .wdata (fpu_rsp.result),
      .raddr (rf_raddr),
      .rdata (rf_rdata)
   );

   gpe_fpu u_fpu (
      .clock   (clock),
      .reset   (reset),
      .fpu_req (fpu_req),
      .fpu_rsp (fpu_rsp)
   );

   assign req_ch.ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign accept       = req_ch.valid && req_ch.ready;
   assign n_run = ({1'b0, pl_ff} > CNT_W'(PROGRAM_DEPTH)) ? CNT_W'(PROGRAM_DEPTH)
                                                          : {1'b0, pl_ff};
   assign pc_next = pc_ff + 1'b1;

   assign inst_we  = accept && (req_ch.op == OP_WRITE_INSTR)
                     && ({1'b0, req_ch.slot} < CNT_W'(PROGRAM_DEPTH));
   assign const_we = accept && (req_ch.op == OP_WRITE_CONST)
                     && ({1'b0, req_ch.slot} < CNT_W'(CONST_COUNT));

   always_comb begin
      case (k_ff)
         3'd0:    src_cur = instr_ff[24:20];
         3'd1:    src_cur = instr_ff[19:15];
         3'd2:    src_cur = instr_ff[14:10];
         3'd3:    src_cur = instr_ff[9:5];
         default: src_cur = instr_ff[4:0];
      endcase
   end

   assign inst_raddr  = pc_ff[IADDR_W-1:0];
   assign const_raddr = src_cur[CADDR_W-1:0];

   always_comb begin
      case (state_ff)
         S_OUTA:  rf_raddr = REG_OUTX;
         S_OUTX:  rf_raddr = REG_OUTY;
         default: rf_raddr = src_cur[RADDR_W-1:0];
      endcase
   end

   always_comb begin
      case (src_cur) inside
         [5'd0:SRC_LAST_REG]: begin
            src_val = rf_valid_ff[src_cur[RADDR_W-1:0]] ? rf_rdata : 32'd0;
         end
         [SRC_CONST0:SRC_CONST_END]: begin
            src_val = (({1'b0, src_cur[3:0]} < CNT_W'(CONST_COUNT))
                       && const_valid_ff[src_cur[CADDR_W-1:0]]) ? const_rdata : 32'd0;
         end
         SRC_ONE:      src_val = FP_ONE;
         SRC_MINUSONE: src_val = FP_MINUSONE;
         default:      src_val = 32'd0;
      endcase
   end

   assign dec_word = inst_valid_ff[pc_ff[IADDR_W-1:0]] ? inst_rdata : 32'd0;
   assign bad_src  = !readable(dec_word[24:20]) || !readable(dec_word[19:15])
                     || !readable(dec_word[14:10]) || !readable(dec_word[9:5])
                     || !readable(dec_word[4:0]);
   assign bad_opc  = (dec_word[30:29] != OPC_DOT) && (dec_word[30:29] != OPC_SQRTMUL);
   assign bad_dst  = (dec_word[28:25] > DST_LAST);

   always_comb begin
      fpu_active = 1'b1;
      fpu_req.op = FPU_MUL;
      fpu_req.a  = opnd_ff[0];
      fpu_req.b  = opnd_ff[1];
      case (state_ff)
         S_CVTX: begin
            fpu_req.op = FPU_CVT; fpu_req.a = {16'd0, px_ff};
         end
         S_CVTY: begin
            fpu_req.op = FPU_CVT; fpu_req.a = {16'd0, py_ff};
         end
         S_SQRT: fpu_req.op = FPU_SQRT;
         S_MUL1: fpu_req.op = FPU_MUL;
         S_MUL2: begin
            fpu_req.a = opnd_ff[2]; fpu_req.b = opnd_ff[3];
         end
         S_ADD1: begin
            fpu_req.op = FPU_ADD; fpu_req.b = opnd_ff[2];
         end
         S_ADD2: begin
            fpu_req.op = FPU_ADD; fpu_req.b = opnd_ff[4];
         end
         default: fpu_active = 1'b0;
      endcase
      fpu_req.start = fpu_active && !fpu_wait_ff;
   end

   always_comb begin
      state_in       = state_ff;
      pl_in          = pl_ff;
      inst_valid_in  = inst_valid_ff;
      const_valid_in = const_valid_ff;
      rf_valid_in    = rf_valid_ff;
      px_in          = px_ff;
      py_in          = py_ff;
      pc_in          = pc_ff;
      k_in           = k_ff;
      instr_in       = instr_ff;
      opnd_in        = opnd_ff;
      rsp_valid_in   = rsp_valid_ff;
      out_x_in       = out_x_ff;
      out_y_in       = out_y_ff;
      error_in       = error_ff;
      rf_we          = 1'b0;
      rf_waddr       = instr_ff[28:25];
      fpu_wait_in    = fpu_wait_ff;

      if (fpu_req.start) begin
         fpu_wait_in = 1'b1;
      end else if (fpu_rsp.done) begin
         fpu_wait_in = 1'b0;
      end

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (psel && penable && pwrite && !paddr[2]) begin
         pl_in = pwdata[3:0];
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               out_x_in = '0;
               out_y_in = '0;
               error_in = ERR_NONE;
               case (req_ch.op)
                  OP_WRITE_INSTR: begin
                     rsp_valid_in = 1'b1;
                     if (inst_we) begin
                        inst_valid_in[req_ch.slot[IADDR_W-1:0]] = 1'b1;
                     end else begin
                        error_in = ERR_SLOT;
                     end
                  end
                  OP_WRITE_CONST: begin
                     rsp_valid_in = 1'b1;
                     if (const_we) begin
                        const_valid_in[req_ch.slot[CADDR_W-1:0]] = 1'b1;
                     end else begin
                        error_in = ERR_SLOT;
                     end
                  end
                  OP_EVAL: begin
                     px_in = req_ch.pixel_x;
                     py_in = req_ch.pixel_y;
                     rf_valid_in = '0;
                     state_in = S_CVTX;
                  end
                  default: rsp_valid_in = 1'b1;
               endcase
            end
         end
         S_CVTX: begin
            if (fpu_rsp.done) begin
               rf_we = 1'b1;
               rf_waddr = REG_X;
               rf_valid_in[REG_X] = 1'b1;
               state_in = S_CVTY;
            end
         end
         S_CVTY: begin
            if (fpu_rsp.done) begin
               rf_we = 1'b1;
               rf_waddr = REG_Y;
               rf_valid_in[REG_Y] = 1'b1;
               pc_in = '0;
               state_in = (n_run == '0) ? S_OUTA : S_IFETCH;
            end
         end
         S_IFETCH: state_in = S_IDEC;
         S_IDEC: begin
            instr_in = dec_word;
            k_in = '0;
            if (bad_src || bad_opc || bad_dst) begin
               error_in = bad_src ? ERR_SOURCE : (bad_opc ? ERR_OPCODE : ERR_DEST);
               out_x_in = '0;
               out_y_in = '0;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end else begin
               state_in = S_SRCA;
            end
         end
         S_SRCA: state_in = S_SRCD;
         S_SRCD: begin
            opnd_in[k_ff] = src_val;
            k_in = k_ff + 1'b1;
            if (k_ff == 3'd4) begin
               state_in = (instr_ff[30:29] == OPC_SQRTMUL) ? S_SQRT : S_MUL1;
            end else begin
               state_in = S_SRCA;
            end
         end
         S_SQRT: begin
            if (fpu_rsp.done) begin
               opnd_in[0] = fpu_rsp.result;
               state_in = S_MUL1;
            end
         end
         S_MUL1: begin
            if (fpu_rsp.done) begin
               opnd_in[0] = fpu_rsp.result;
               state_in = S_MUL2;
            end
         end
         S_MUL2: begin
            if (fpu_rsp.done) begin
               opnd_in[2] = fpu_rsp.result;
               state_in = S_ADD1;
            end
         end
         S_ADD1: begin
            if (fpu_rsp.done) begin
               opnd_in[0] = fpu_rsp.result;
               state_in = S_ADD2;
            end
         end
         S_ADD2: begin
            if (fpu_rsp.done) begin
               rf_we = 1'b1;
               rf_valid_in[instr_ff[28:25]] = 1'b1;
               pc_in = pc_next;
               state_in = (pc_next < n_run) ? S_IFETCH : S_OUTA;
            end
         end
         S_OUTA: state_in = S_OUTX;
         S_OUTX: begin
            out_x_in = rf_valid_ff[REG_OUTX] ? rf_rdata : 32'd0;
            state_in = S_OUTY;
         end
         S_OUTY: begin
            out_y_in = rf_valid_ff[REG_OUTY] ? rf_rdata : 32'd0;
            error_in = ERR_NONE;
            rsp_valid_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         pl_ff          <= '0;
         inst_valid_ff  <= '0;
         const_valid_ff <= '0;
         rf_valid_ff    <= '0;
         fpu_wait_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         pl_ff          <= pl_in;
         inst_valid_ff  <= inst_valid_in;
         const_valid_ff <= const_valid_in;
         rf_valid_ff    <= rf_valid_in;
         fpu_wait_ff    <= fpu_wait_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      px_ff    <= px_in;
      py_ff    <= py_in;
      pc_ff    <= pc_in;
      k_ff     <= k_in;
      instr_ff <= instr_in;
      opnd_ff  <= opnd_in;
      out_x_ff <= out_x_in;
      out_y_ff <= out_y_in;
      error_ff <= error_in;
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.out_x = out_x_ff;
   assign rsp_ch.out_y = out_y_ff;
   assign rsp_ch.error = error_ff;

   assign pready = 1'b1;
   assign prdata = paddr[2] ? 32'd0 : {28'd0, pl_ff};
endmodule

`default_nettype wire

// ----- sim/tb_gpe_pkg_dummy.sv -----
// Testbench helper package: float bit conversions and square root for the
// gradient program evaluator predictor. Depends on nothing.
`timescale 1ns / 1ps

package tb_fp_pkg;

   // single bits to real, exact
   function automatic real sp_to_real(input logic [31:0] b);
      logic [63:0] d;
      logic [7:0]  ex;
      logic [22:0] fr;
      int          e;
      logic [23:0] m;
      ex = b[30:23];
      fr = b[22:0];
      d = '0;
      d[63] = b[31];
      if (ex == 8'hFF) begin
         d[62:52] = 11'h7FF;
         d[51:29] = fr;
         if (fr != 0) d[51] = 1'b1;
      end else if (ex != 0) begin
         d[62:52] = 11'(ex - 127 + 1023);
         d[51:29] = fr;
      end else if (fr != 0) begin
         m = {1'b0, fr};
         e = -126;
         while (m[23] == 1'b0) begin
            m = m << 1;
            e = e - 1;
         end
         d[62:52] = 11'(e + 1023);
         d[51:29] = m[22:0];
      end
      return $bitstoreal(d);
   endfunction

   // real to single bits, round to nearest even; NaN maps to the quiet NaN
   function automatic logic [31:0] real_to_sp(input real r);
      logic [63:0]       d;
      logic [10:0]       ex;
      logic [52:0]       m;
      int                e_unb, sh;
      longint unsigned   kept, rem, half;
      logic [31:0]       res;
      d = $realtobits(r);
      ex = d[62:52];
      if (ex == 11'h7FF) begin
         if (d[51:0] != 0) return 32'h7FC0_0000;
         return {d[63], 31'h7F80_0000};
      end
      if (d[62:0] == 0) return {d[63], 31'h0};
      if (ex == 0) return {d[63], 31'h0};
      e_unb = int'(ex) - 1023;
      m = {1'b1, d[51:0]};
      if (e_unb >= -126) sh = 29;
      else sh = 29 + (-126 - e_unb);
      if (sh >= 60) return {d[63], 31'h0};
      kept = 64'(m) >> sh;
      rem = 64'(m) & ((64'd1 << sh) - 1);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && kept[0])) kept = kept + 1;
      if (e_unb >= -126) begin
         if (e_unb + 127 >= 255) return {d[63], 31'h7F80_0000};
         res = 32'((e_unb + 127) << 23) + 32'(kept - 64'h80_0000);
      end else begin
         res = 32'(kept);
      end
      if (res[30:0] >= 31'h7F80_0000) res[30:0] = 31'h7F80_0000;
      res[31] = d[63];
      return res;
   endfunction

   function automatic logic [31:0] sp_sqrt(input logic [31:0] x);
      logic [7:0]      ex;
      logic [22:0]     fr;
      logic [31:0]     m;
      int              e;
      longint unsigned rem, q, bitv;
      ex = x[30:23];
      fr = x[22:0];
      if (ex == 8'hFF && fr != 0) return x | 32'h0040_0000;
      if (x[30:0] == 0) return x;
      if (x[31]) return 32'h7FC0_0000;
      if (ex == 8'hFF) return x;
      if (ex == 0) begin
         m = {9'b0, fr};
         e = -126;
         while (m < 32'h80_0000) begin
            m = m << 1;
            e = e - 1;
         end
      end else begin
         m = {9'b1, fr};
         e = int'(ex) - 127;
      end
      if ((e % 2) != 0) begin
         m = m << 1;
         e = e - 1;
      end
      rem = 64'(m) << 23;
      q = 0;
      bitv = 64'd1 << 48;
      while (bitv != 0) begin
         if (rem >= q + bitv) begin
            rem = rem - (q + bitv);
            q = (q >> 1) + bitv;
         end else begin
            q = q >> 1;
         end
         bitv = bitv >> 2;
      end
      if (rem > q) q = q + 1;
      return 32'((e / 2 + 126) << 23) + 32'(q);
   endfunction

   function automatic bit is_nan(input logic [31:0] b);
      return b[30:23] == 8'hFF && b[22:0] != 0;
   endfunction

endpackage

// ----- sim/tb_top.sv -----
// Testbench top of the gradient program evaluator: directed and random load and
// pixel words, checked against a float predictor. Depends on gpe_pkg, the
// channel interfaces, the RTL and tb_fp_pkg.
`timescale 1ns / 1ps

module tb_top import gpe_pkg::*, tb_fp_pkg::*;;

   typedef struct {
      logic [31:0] out_x;
      logic [31:0] out_y;
      logic [2:0]  error;
   } gpe_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   gpe_req_if req_ch();
   gpe_rsp_if rsp_ch();

   gradient_program_evaluator uut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   logic [31:0] instr_mem [PROGRAM_DEPTH];
   logic [31:0] const_mem [CONST_COUNT];
   logic [3:0]  prog_len;

   gpe_result_type pending_results[$];
   int          mismatches = 0;
   int          tx_idle = 0, rx_idle = 0;
   int          hold_off = 0;
   longint      cycles = 0;

   initial begin
      req_ch.valid = 1'b0;
      req_ch.op = '0;
      req_ch.slot = '0;
      req_ch.word = '0;
      req_ch.pixel_x = '0;
      req_ch.pixel_y = '0;
      rsp_ch.ready = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles = cycles + 1;
      if (cycles > 64'd4_000_000) begin
         $display("gradient_program_evaluator: mismatch");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (hold_off > 0) begin
         rsp_ch.ready = 1'b0;
         hold_off = hold_off - 1;
      end else begin
         rsp_ch.ready = ($urandom_range(0, 99) >= rx_idle);
      end
   end

   function automatic bit fp_same(input logic [31:0] a, input logic [31:0] b);
      if (is_nan(a) && is_nan(b)) return 1'b1;
      return a == b;
   endfunction

   always @(posedge clock) begin
      gpe_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_results.size() == 0) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10)
               $display("unexpected word: x=%h y=%h err=%0d",
                        rsp_ch.out_x, rsp_ch.out_y, rsp_ch.error);
         end else begin
            want = pending_results.pop_front();
            if (!fp_same(want.out_x, rsp_ch.out_x) || !fp_same(want.out_y, rsp_ch.out_y)
                || want.error != rsp_ch.error) begin
               mismatches = mismatches + 1;
               if (mismatches <= 10)
                  $display("mismatch: exp x=%h y=%h err=%0d got x=%h y=%h err=%0d",
                           want.out_x, want.out_y, want.error,
                           rsp_ch.out_x, rsp_ch.out_y, rsp_ch.error);
            end
         end
      end
   end

   function automatic bit src_ok(input logic [4:0] s);
      return s <= SRC_LAST_REG || (s >= SRC_CONST0 && s <= SRC_MINUSONE);
   endfunction

   function automatic gpe_result_type run_pixel(input logic signed [15:0] px,
                                                input logic signed [15:0] py);
      logic [31:0] regs [32];
      logic [31:0] w, va;
      logic [4:0]  src [5];
      logic [3:0]  dst;
      logic [1:0]  opc;
      logic [31:0] p1, p2, s;
      int          n;
      gpe_result_type r;
      r.out_x = '0;
      r.out_y = '0;
      r.error = ERR_NONE;
      for (int i = 0; i < 32; i++) regs[i] = '0;
      regs[0] = real_to_sp(real'(px));
      regs[1] = real_to_sp(real'(py));
      for (int i = 0; i < 12; i++) regs[16 + i] = (i < CONST_COUNT) ? const_mem[i] : '0;
      regs[29] = FP_ONE;
      regs[30] = FP_MINUSONE;
      n = (prog_len > PROGRAM_DEPTH) ? PROGRAM_DEPTH : prog_len;
      for (int i = 0; i < n; i++) begin
         w = instr_mem[i];
         dst = w[28:25];
         opc = w[30:29];
         for (int k = 0; k < 5; k++) begin
            src[k] = w[5*k +: 5];
            if (!src_ok(src[k])) begin
               r.error = ERR_SOURCE;
               return r;
            end
         end
         if (opc != OPC_DOT && opc != OPC_SQRTMUL) begin
            r.error = ERR_OPCODE;
            return r;
         end
         if (dst > DST_LAST) begin
            r.error = ERR_DEST;
            return r;
         end
         va = regs[src[4]];
         if (opc == OPC_SQRTMUL) va = sp_sqrt(va);
         p1 = real_to_sp(sp_to_real(va) * sp_to_real(regs[src[3]]));
         p2 = real_to_sp(sp_to_real(regs[src[2]]) * sp_to_real(regs[src[1]]));
         s = real_to_sp(sp_to_real(p1) + sp_to_real(p2));
         regs[dst] = real_to_sp(sp_to_real(s) + sp_to_real(regs[src[0]]));
      end
      r.out_x = regs[8];
      r.out_y = regs[9];
      return r;
   endfunction

   function automatic gpe_result_type apply_word(input logic [1:0] op, input logic [3:0] slot,
                                                 input logic [31:0] w,
                                                 input logic signed [15:0] px,
                                                 input logic signed [15:0] py);
      gpe_result_type r;
      r.out_x = '0;
      r.out_y = '0;
      r.error = ERR_NONE;
      if (op == OP_WRITE_INSTR) begin
         if (slot < PROGRAM_DEPTH) instr_mem[slot] = w;
         else r.error = ERR_SLOT;
      end else if (op == OP_WRITE_CONST) begin
         if (slot < CONST_COUNT) const_mem[slot] = w;
         else r.error = ERR_SLOT;
      end else if (op == OP_EVAL) begin
         r = run_pixel(px, py);
         if (r.error != ERR_NONE) begin
            r.out_x = '0;
            r.out_y = '0;
         end
      end
      return r;
   endfunction

   task automatic send_word(input logic [1:0] op, input logic [3:0] slot,
                            input logic [31:0] w, input logic signed [15:0] px,
                            input logic signed [15:0] py);
      while ($urandom_range(0, 99) < tx_idle) begin
         @(negedge clock);
         req_ch.valid = 1'b0;
      end
      @(negedge clock);
      req_ch.valid = 1'b1;
      req_ch.op = op;
      req_ch.slot = slot;
      req_ch.word = w;
      req_ch.pixel_x = px;
      req_ch.pixel_y = py;
      do @(posedge clock); while (!req_ch.ready);
      pending_results.push_back(apply_word(op, slot, w, px, py));
   endtask

   task automatic end_burst();
      @(negedge clock);
      req_ch.valid = 1'b0;
   endtask

   task automatic wait_drained();
      end_burst();
      while (pending_results.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic set_length(input logic [31:0] value);
      wait_drained();
      @(negedge clock);
      psel = 1'b1;
      pwrite = 1'b1;
      penable = 1'b0;
      paddr = '0;
      pwdata = value;
      @(negedge clock);
      penable = 1'b1;
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      prog_len = value[3:0];
   endtask

   function automatic logic [31:0] instr(input logic [1:0] opc, input logic [3:0] dst,
                                         input logic [4:0] a, input logic [4:0] b,
                                         input logic [4:0] c, input logic [4:0] d,
                                         input logic [4:0] e);
      return {1'($urandom_range(0, 1)), opc, dst, a, b, c, d, e};
   endfunction

   function automatic logic [4:0] rand_src();
      int r;
      r = $urandom_range(0, 24);
      return (r < 10) ? 5'(r) : 5'(r + 6);
   endfunction

   function automatic logic [31:0] rand_instr();
      return instr($urandom_range(0, 1) ? OPC_SQRTMUL : OPC_DOT,
                   4'($urandom_range(0, 9)), rand_src(), rand_src(), rand_src(),
                   rand_src(), rand_src());
   endfunction

   function automatic logic [31:0] rand_const();
      if ($urandom_range(0, 15) == 0) return $urandom;
      return {1'($urandom_range(0, 1)), 8'($urandom_range(118, 136)), 23'($urandom)};
   endfunction

   function automatic logic signed [15:0] rand_coord();
      if ($urandom_range(0, 3) == 0) return 16'($urandom);
      return 16'($signed($urandom_range(0, 200)) - 100);
   endfunction

   task automatic test_directed_loads();
      send_word(OP_EVAL, 4'd0, 32'h0, 16'sh7FFF, -16'sh8000);
      send_word(OP_WRITE_CONST, 4'd0, 32'h4000_0000, 0, 0);
      send_word(OP_WRITE_CONST, 4'd11, 32'hFFFF_FFFF, 16'shFFFF, 16'shFFFF);
      send_word(OP_WRITE_INSTR, 4'd0,
                instr(OPC_DOT, REG_OUTX, 5'd0, SRC_ONE, 5'd1, SRC_CONST0, SRC_MINUSONE),
                0, 0);
      send_word(OP_WRITE_INSTR, 4'd1,
                instr(OPC_SQRTMUL, REG_OUTY, 5'd1, SRC_ONE, 5'd28, 5'd28, 5'd0), 0, 0);
      send_word(OP_WRITE_INSTR, 4'd8, 32'hFFFF_FFFF, 0, 0);
      send_word(OP_WRITE_CONST, 4'd12, 32'h1234_5678, 0, 0);
      send_word(OP_WRITE_CONST, 4'd15, 32'h0, 0, 0);
      send_word(2'd3, 4'd5, 32'hFFFF_FFFF, 16'sh7FFF, 16'sh7FFF);
      set_length(32'd2);
      send_word(OP_EVAL, 4'hF, 32'hFFFF_FFFF, 16'sh7FFF, -16'sh8000);
      send_word(OP_EVAL, 4'd0, 32'h0, -16'sd4, 16'sd9);
      send_word(OP_EVAL, 4'd0, 32'h0, 16'sd0, 16'sd0);
   endtask

   task automatic test_error_cases();
      set_length(32'd1);
      send_word(OP_WRITE_INSTR, 4'd0, instr(OPC_DOT, 4'd8, 5'd0, 5'd0, 5'd0, 5'd0, 5'd10), 0, 0);
      send_word(OP_EVAL, 4'd0, 32'h0, 16'sd3, 16'sd3);
      send_word(OP_WRITE_INSTR, 4'd0, instr(OPC_DOT, 4'd8, 5'd31, 5'd0, 5'd0, 5'd0, 5'd0), 0, 0);
      send_word(OP_EVAL, 4'd0, 32'h0, 16'sd3, 16'sd3);
      send_word(OP_WRITE_INSTR, 4'd0, instr(2'd1, 4'd8, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0), 0, 0);
      send_word(OP_EVAL, 4'd0, 32'h0, 16'sd3, 16'sd3);
      send_word(OP_WRITE_INSTR, 4'd0, instr(2'd3, 4'd15, 5'd15, 5'd0, 5'd0, 5'd0, 5'd0), 0, 0);
      send_word(OP_EVAL, 4'd0, 32'h0, 16'sd3, 16'sd3);
      send_word(OP_WRITE_INSTR, 4'd0, instr(OPC_DOT, 4'd10, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0), 0, 0);
      send_word(OP_EVAL, 4'd0, 32'h0, 16'sd3, 16'sd3);
      // negative and negative-zero square roots
      send_word(OP_WRITE_INSTR, 4'd0,
                instr(OPC_SQRTMUL, REG_OUTX, SRC_MINUSONE, SRC_ONE, 5'd28, 5'd28, 5'd28), 0, 0);
      send_word(OP_WRITE_CONST, 4'd1, 32'h8000_0000, 0, 0);
      send_word(OP_WRITE_INSTR, 4'd1,
                instr(OPC_SQRTMUL, REG_OUTY, 5'd17, SRC_ONE, 5'd28, 5'd28, 5'd17), 0, 0);
      set_length(32'hFFFF_FFF2);
      send_word(OP_EVAL, 4'd0, 32'h0, 16'sd1, 16'sd1);
      wait_drained();
   endtask

   task automatic test_random_programs(input int tx, input int rx, input int items);
      int sent;
      int plen;
      sent = 0;
      tx_idle = tx;
      rx_idle = rx;
      while (sent < items) begin
         plen = $urandom_range(0, 3) == 0 ? $urandom_range(0, 15) : $urandom_range(4, 8);
         set_length({28'($urandom), 4'(plen)});
         for (int i = 0; i < PROGRAM_DEPTH; i++) begin
            if ($urandom_range(0, 19) == 0)
               send_word(OP_WRITE_INSTR, 4'(i), $urandom, 0, 0);
            else
               send_word(OP_WRITE_INSTR, 4'(i), rand_instr(), rand_coord(), rand_coord());
         end
         for (int i = 0; i < 4; i++)
            send_word(OP_WRITE_CONST, 4'($urandom_range(0, 11)), rand_const(), 0, 0);
         sent = sent + 12;
         for (int i = 0; i < 8; i++) begin
            if ($urandom_range(0, 9) == 0)
               send_word(2'($urandom), 4'($urandom), $urandom, 16'($urandom), 16'($urandom));
            else
               send_word(OP_EVAL, 4'($urandom), $urandom, rand_coord(), rand_coord());
            sent = sent + 1;
         end
      end
   endtask

   task automatic test_backpressure();
      tx_idle = 0;
      rx_idle = 0;
      set_length(32'd3);
      hold_off = 2500;
      for (int i = 0; i < 20; i++) send_word(OP_EVAL, 4'd0, 32'h0, rand_coord(), rand_coord());
      wait_drained();
   endtask

   initial begin
      for (int i = 0; i < PROGRAM_DEPTH; i++) instr_mem[i] = '0;
      for (int i = 0; i < CONST_COUNT; i++) const_mem[i] = '0;
      prog_len = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed_loads();
      test_error_cases();
      test_random_programs(35, 71, 380);
      test_random_programs(71, 35, 380);
      test_random_programs(0, 0, 380);
      test_backpressure();
      set_length(32'd15);
      wait_drained();
      if (mismatches == 0) begin
         $display("gradient_program_evaluator: match");
      end else begin
         $display("gradient_program_evaluator: mismatch");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/gpe_pkg.sv
rtl/gpe_req_if.sv
rtl/gpe_rsp_if.sv
rtl/gpe_ram.sv
rtl/gpe_fpu.sv
rtl/gradient_program_evaluator.sv
sim/tb_gpe_pkg_dummy.sv
sim/tb_top.sv
